// ===== src/napsrch_pkg.sv =====
package napsrch_pkg;

  localparam int COORD_W = 24;
  localparam int DIST_W  = 25;
  localparam int COS_W   = 16;
  localparam int SEG_QB  = 24;   // fraction bits of the segment parameter
  localparam int UNIT_QB = 28;   // fraction bits of x^2/|v|^2
  localparam int SQ_STEPS = 25;  // root bits out of a 50-bit radicand
  localparam int IN_W  = 8 * COORD_W;
  localparam int OUT_W = 144;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_CIRCLE = 2'd1;
  localparam logic [1:0] FUNC_QUAD   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  typedef enum logic [3:0] {
    M_NONE, M_RX_VX, M_RY_VY, M_VX_VX, M_VY_VY, M_VX_T, M_VY_T,
    M_WX_WX, M_WY_WY, M_UX_HX, M_UY_HY
  } msel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } aop_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_W_FROM_B, OP_PT_A, OP_MID, OP_VEC, OP_SAVE_NUM,
    OP_SAVE_DEN, OP_PT_S, OP_PT_E, OP_DIV_INIT_SEG, OP_DIV_INIT_UNIT,
    OP_DIV_STEP, OP_PT_X, OP_PT_Y, OP_W_FROM_P, OP_SAVE_N, OP_SQ_INIT_N,
    OP_SQ_INIT_Q, OP_SQ_STEP, OP_SAVE_DIST, OP_UNIT_X, OP_UNIT_Y,
    OP_SET_HEAD, OP_UPDATE, OP_PUBLISH
  } op_t;

  typedef struct packed {
    msel_t msel;
    aop_t  aop;
    op_t   op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       num_le0;
    logic       num_ge_den;
    logic       den_zero;
    logic       out_full;
  } dp_stat_t;

endpackage

// ===== src/napsrch_ctrl.sv =====
module napsrch_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  output logic                 in_ready,
  input  napsrch_pkg::dp_stat_t stat,
  output napsrch_pkg::dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_Q_VEC, S_Q_M0, S_Q_M1, S_Q_M2, S_Q_M3, S_Q_M4, S_Q_M5,
    S_Q_DEC, S_Q_DIV, S_Q_T0, S_Q_T1, S_Q_T2, S_C_W, S_U_M0, S_U_M1, S_U_M2,
    S_U_N, S_D_INIT, S_D_SQ, S_D_SAVE, S_U_CM, S_U_DI, S_U_DV, S_U_SI, S_U_SQ,
    S_U_SET, S_ST_SET, S_K_M0, S_K_M1, S_K_M2, S_K_UPD
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic       comp_y;
  logic       fin;

  assign in_ready = (state == S_IDLE) && !fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      comp_y <= 1'b0;
      fin    <= 1'b0;
    end else begin
      if (fin) begin
        if (!stat.out_full) fin <= 1'b0;
      end else begin
        unique case (state)
          S_IDLE:   if (in_fire) state <= S_DISP;
          S_DISP: begin
            unique case (stat.func)
              napsrch_pkg::FUNC_START:  state <= S_U_M0;
              napsrch_pkg::FUNC_CIRCLE: state <= S_C_W;
              napsrch_pkg::FUNC_QUAD:   state <= S_Q_VEC;
              default: begin
                state <= S_IDLE;
                fin   <= 1'b1;
              end
            endcase
          end
          S_Q_VEC:  state <= S_Q_M0;
          S_Q_M0:   state <= S_Q_M1;
          S_Q_M1:   state <= S_Q_M2;
          S_Q_M2:   state <= S_Q_M3;
          S_Q_M3:   state <= S_Q_M4;
          S_Q_M4:   state <= S_Q_M5;
          S_Q_M5:   state <= S_Q_DEC;
          S_Q_DEC: begin
            if (stat.den_zero || stat.num_le0 || stat.num_ge_den) begin
              state <= S_C_W;
            end else begin
              state <= S_Q_DIV;
              cnt   <= 5'(napsrch_pkg::SEG_QB - 1);
            end
          end
          S_Q_DIV: begin
            if (cnt == '0) state <= S_Q_T0;
            else cnt <= cnt - 5'd1;
          end
          S_Q_T0:   state <= S_Q_T1;
          S_Q_T1:   state <= S_Q_T2;
          S_Q_T2:   state <= S_C_W;
          S_C_W:    state <= S_U_M0;
          S_U_M0:   state <= S_U_M1;
          S_U_M1:   state <= S_U_M2;
          S_U_M2:   state <= S_U_N;
          S_U_N: begin
            comp_y <= 1'b0;
            state  <= (stat.func == napsrch_pkg::FUNC_START) ? S_U_CM : S_D_INIT;
          end
          S_D_INIT: begin
            state <= S_D_SQ;
            cnt   <= 5'(napsrch_pkg::SQ_STEPS - 1);
          end
          S_D_SQ: begin
            if (cnt == '0) state <= S_D_SAVE;
            else cnt <= cnt - 5'd1;
          end
          S_D_SAVE: state <= S_U_CM;
          S_U_CM:   state <= S_U_DI;
          S_U_DI: begin
            state <= S_U_DV;
            cnt   <= 5'(napsrch_pkg::UNIT_QB - 1);
          end
          S_U_DV: begin
            if (cnt == '0) state <= S_U_SI;
            else cnt <= cnt - 5'd1;
          end
          S_U_SI: begin
            state <= S_U_SQ;
            cnt   <= 5'(napsrch_pkg::SQ_STEPS - 1);
          end
          S_U_SQ: begin
            if (cnt == '0) state <= S_U_SET;
            else cnt <= cnt - 5'd1;
          end
          S_U_SET: begin
            if (!comp_y) begin
              comp_y <= 1'b1;
              state  <= S_U_CM;
            end else begin
              state <= (stat.func == napsrch_pkg::FUNC_START) ? S_ST_SET : S_K_M0;
            end
          end
          S_ST_SET: begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end
          S_K_M0:   state <= S_K_M1;
          S_K_M1:   state <= S_K_M2;
          S_K_M2:   state <= S_K_UPD;
          // dot product sits in acc now
          S_K_UPD: begin
            state <= S_IDLE;
            fin   <= 1'b1;
          end
          default:  state <= S_IDLE;
        endcase
      end
    end
  end

  // command decode
  always_comb begin
    cmd.msel = napsrch_pkg::M_NONE;
    cmd.aop  = napsrch_pkg::ACC_HOLD;
    cmd.op   = napsrch_pkg::OP_NONE;
    if (fin) begin
      if (!stat.out_full) cmd.op = napsrch_pkg::OP_PUBLISH;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) cmd.op = napsrch_pkg::OP_LOAD;
        S_DISP: begin
          unique case (stat.func)
            napsrch_pkg::FUNC_START:  cmd.op = napsrch_pkg::OP_W_FROM_B;
            napsrch_pkg::FUNC_CIRCLE: cmd.op = napsrch_pkg::OP_PT_A;
            napsrch_pkg::FUNC_QUAD:   cmd.op = napsrch_pkg::OP_MID;
            default:                  cmd.op = napsrch_pkg::OP_NONE;
          endcase
        end
        S_Q_VEC: cmd.op = napsrch_pkg::OP_VEC;
        S_Q_M0:  cmd.msel = napsrch_pkg::M_RX_VX;
        S_Q_M1: begin
          cmd.msel = napsrch_pkg::M_RY_VY;
          cmd.aop  = napsrch_pkg::ACC_LOAD;
        end
        S_Q_M2: begin
          cmd.msel = napsrch_pkg::M_VX_VX;
          cmd.aop  = napsrch_pkg::ACC_ADD;
        end
        S_Q_M3: begin
          cmd.msel = napsrch_pkg::M_VY_VY;
          cmd.aop  = napsrch_pkg::ACC_LOAD;
          cmd.op   = napsrch_pkg::OP_SAVE_NUM;
        end
        S_Q_M4: cmd.aop = napsrch_pkg::ACC_ADD;
        S_Q_M5: cmd.op  = napsrch_pkg::OP_SAVE_DEN;
        S_Q_DEC: begin
          if (stat.den_zero || stat.num_le0) cmd.op = napsrch_pkg::OP_PT_S;
          else if (stat.num_ge_den)          cmd.op = napsrch_pkg::OP_PT_E;
          else                               cmd.op = napsrch_pkg::OP_DIV_INIT_SEG;
        end
        S_Q_DIV: cmd.op   = napsrch_pkg::OP_DIV_STEP;
        S_Q_T0:  cmd.msel = napsrch_pkg::M_VX_T;
        S_Q_T1: begin
          cmd.msel = napsrch_pkg::M_VY_T;
          cmd.op   = napsrch_pkg::OP_PT_X;
        end
        S_Q_T2:  cmd.op   = napsrch_pkg::OP_PT_Y;
        S_C_W:   cmd.op   = napsrch_pkg::OP_W_FROM_P;
        S_U_M0:  cmd.msel = napsrch_pkg::M_WX_WX;
        S_U_M1: begin
          cmd.msel = napsrch_pkg::M_WY_WY;
          cmd.aop  = napsrch_pkg::ACC_LOAD;
        end
        S_U_M2:   cmd.aop = napsrch_pkg::ACC_ADD;
        S_U_N:    cmd.op  = napsrch_pkg::OP_SAVE_N;
        S_D_INIT: cmd.op  = napsrch_pkg::OP_SQ_INIT_N;
        S_D_SQ:   cmd.op  = napsrch_pkg::OP_SQ_STEP;
        S_D_SAVE: cmd.op  = napsrch_pkg::OP_SAVE_DIST;
        S_U_CM:   cmd.msel = comp_y ? napsrch_pkg::M_WY_WY : napsrch_pkg::M_WX_WX;
        S_U_DI:   cmd.op  = napsrch_pkg::OP_DIV_INIT_UNIT;
        S_U_DV:   cmd.op  = napsrch_pkg::OP_DIV_STEP;
        S_U_SI:   cmd.op  = napsrch_pkg::OP_SQ_INIT_Q;
        S_U_SQ:   cmd.op  = napsrch_pkg::OP_SQ_STEP;
        S_U_SET:  cmd.op  = comp_y ? napsrch_pkg::OP_UNIT_Y : napsrch_pkg::OP_UNIT_X;
        S_ST_SET: cmd.op  = napsrch_pkg::OP_SET_HEAD;
        S_K_M0:   cmd.msel = napsrch_pkg::M_UX_HX;
        S_K_M1: begin
          cmd.msel = napsrch_pkg::M_UY_HY;
          cmd.aop  = napsrch_pkg::ACC_LOAD;
        end
        S_K_M2: begin
          cmd.aop = napsrch_pkg::ACC_ADD;
        end
        S_K_UPD:  cmd.op  = napsrch_pkg::OP_UPDATE;
        default: cmd.op = napsrch_pkg::OP_NONE;
      endcase
    end
  end

endmodule

// ===== src/napsrch_dp.sv =====
module napsrch_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  napsrch_pkg::dp_cmd_t            cmd,
  output napsrch_pkg::dp_stat_t           stat,
  input  logic [1:0]                      in_func,
  input  logic [napsrch_pkg::IN_W-1:0]    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [napsrch_pkg::OUT_W-1:0]   out_data
);

  localparam int CW = napsrch_pkg::COORD_W;

  // cosine accumulate ends in the K_M2 cycle; UPDATE reads acc in the cycle after
  logic [1:0]             func;
  logic signed [CW-1:0]   ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [CW-1:0]   ox, oy, sx, sy, ex, ey, px, py;
  logic signed [15:0]     hx, hy, ux, uy;
  logic signed [CW:0]     vx, vy, rx, ry, wx, wy;
  logic signed [25:0]     ma, mb;
  logic signed [51:0]     prod, acc, num;
  logic [49:0]            den, n;
  logic [49:0]            drem, dden;
  logic [27:0]            quot;
  logic                   dsat;
  logic [49:0]            srad;
  logic [25:0]            srem;
  logic [24:0]            sroot;
  logic [24:0]            cand_dist;

  logic                   near_valid, best_valid;
  logic signed [CW-1:0]   near_px, near_py, best_px, best_py;
  logic [24:0]            near_dist;
  logic signed [15:0]     best_cos;

  logic [50:0]            div_r2;
  logic [27:0]            sq_r, sq_trial;
  logic [15:0]            s_rnd;
  logic [28:0]            q_full;
  logic signed [51:0]     csum, cval, tx;
  logic signed [15:0]     cos_c;
  logic signed [CW:0]     sum_ab_x, sum_ab_y, sum_cd_x, sum_cd_y;

  localparam logic signed [51:0] COS_HALF = 52'sd8192;
  localparam logic signed [51:0] COS_POS  = 52'sd16384;
  localparam logic signed [51:0] COS_NEG  = -52'sd16384;
  localparam logic signed [15:0] COS_MIN  = -16'sd16384;
  localparam logic signed [51:0] T_HALF   = 52'sd8388608;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.msel)
      napsrch_pkg::M_RX_VX: begin ma = 26'(rx); mb = 26'(vx); end
      napsrch_pkg::M_RY_VY: begin ma = 26'(ry); mb = 26'(vy); end
      napsrch_pkg::M_VX_VX: begin ma = 26'(vx); mb = 26'(vx); end
      napsrch_pkg::M_VY_VY: begin ma = 26'(vy); mb = 26'(vy); end
      napsrch_pkg::M_VX_T:  begin ma = 26'(vx); mb = {2'b00, quot[23:0]}; end
      napsrch_pkg::M_VY_T:  begin ma = 26'(vy); mb = {2'b00, quot[23:0]}; end
      napsrch_pkg::M_WX_WX: begin ma = 26'(wx); mb = 26'(wx); end
      napsrch_pkg::M_WY_WY: begin ma = 26'(wy); mb = 26'(wy); end
      napsrch_pkg::M_UX_HX: begin ma = 26'(ux); mb = 26'(hx); end
      napsrch_pkg::M_UY_HY: begin ma = 26'(uy); mb = 26'(hy); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    sum_ab_x = 25'(ax) + 25'(bx);
    sum_ab_y = 25'(ay) + 25'(by);
    sum_cd_x = 25'(cx) + 25'(dx);
    sum_cd_y = 25'(cy) + 25'(dy);
    div_r2   = {drem, 1'b0};
    sq_r     = {srem, srad[49:48]};
    sq_trial = {1'b0, sroot, 2'b01};
    s_rnd    = sroot[15:0] + 16'(srem > {1'b0, sroot});
    q_full   = dsat ? 29'h1000_0000 : {1'b0, quot};
    tx       = prod + T_HALF;
    csum     = acc + COS_HALF;
    cval     = csum >>> 14;
    if (cval > COS_POS)      cos_c = 16'sd16384;
    else if (cval < COS_NEG) cos_c = COS_MIN;
    else                     cos_c = cval[15:0];
  end

  assign stat.func       = func;
  assign stat.num_le0    = (num <= 52'sd0);
  assign stat.num_ge_den = (num >= $signed({2'b00, den}));
  assign stat.den_zero   = (den == '0);
  assign stat.out_full   = out_valid;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.aop)
      napsrch_pkg::ACC_LOAD: acc <= prod;
      napsrch_pkg::ACC_ADD:  acc <= acc + prod;
      default:               acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= '0; oy <= '0; hx <= '0; hy <= '0;
      near_valid <= 1'b0; near_px <= '0; near_py <= '0; near_dist <= '0;
      best_valid <= 1'b0; best_px <= '0; best_py <= '0; best_cos <= COS_MIN;
      out_valid <= 1'b0;
      func      <= napsrch_pkg::FUNC_NONE;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        napsrch_pkg::OP_LOAD: begin
          func <= in_func;
          ax <= in_data[CW*1-1:CW*0]; ay <= in_data[CW*2-1:CW*1];
          bx <= in_data[CW*3-1:CW*2]; by <= in_data[CW*4-1:CW*3];
          cx <= in_data[CW*5-1:CW*4]; cy <= in_data[CW*6-1:CW*5];
          dx <= in_data[CW*7-1:CW*6]; dy <= in_data[CW*8-1:CW*7];
        end
        napsrch_pkg::OP_W_FROM_B: begin wx <= 25'(bx); wy <= 25'(by); end
        napsrch_pkg::OP_PT_A: begin px <= ax; py <= ay; end
        napsrch_pkg::OP_MID: begin
          sx <= sum_ab_x[CW:1]; sy <= sum_ab_y[CW:1];
          ex <= sum_cd_x[CW:1]; ey <= sum_cd_y[CW:1];
        end
        napsrch_pkg::OP_VEC: begin
          vx <= 25'(ex) - 25'(sx); vy <= 25'(ey) - 25'(sy);
          rx <= 25'(ox) - 25'(sx); ry <= 25'(oy) - 25'(sy);
        end
        napsrch_pkg::OP_SAVE_NUM: num <= acc;
        napsrch_pkg::OP_SAVE_DEN: den <= acc[49:0];
        napsrch_pkg::OP_PT_S: begin px <= sx; py <= sy; end
        napsrch_pkg::OP_PT_E: begin px <= ex; py <= ey; end
        napsrch_pkg::OP_DIV_INIT_SEG: begin
          drem <= num[49:0]; dden <= den; quot <= '0; dsat <= 1'b0;
        end
        napsrch_pkg::OP_DIV_INIT_UNIT: begin
          drem <= prod[49:0]; dden <= n; quot <= '0;
          dsat <= (prod[49:0] >= n);
        end
        napsrch_pkg::OP_DIV_STEP: begin
          if (div_r2 >= {1'b0, dden}) begin
            drem <= 50'(div_r2 - {1'b0, dden});
            quot <= {quot[26:0], 1'b1};
          end else begin
            drem <= div_r2[49:0];
            quot <= {quot[26:0], 1'b0};
          end
        end
        napsrch_pkg::OP_PT_X: px <= sx + tx[47:24];
        napsrch_pkg::OP_PT_Y: py <= sy + tx[47:24];
        napsrch_pkg::OP_W_FROM_P: begin
          wx <= 25'(px) - 25'(ox); wy <= 25'(py) - 25'(oy);
        end
        napsrch_pkg::OP_SAVE_N: n <= acc[49:0];
        napsrch_pkg::OP_SQ_INIT_N: begin
          srad <= n; srem <= '0; sroot <= '0;
        end
        napsrch_pkg::OP_SQ_INIT_Q: begin
          srad <= {21'd0, q_full}; srem <= '0; sroot <= '0;
        end
        napsrch_pkg::OP_SQ_STEP: begin
          srad <= {srad[47:0], 2'b00};
          if (sq_r >= sq_trial) begin
            srem  <= 26'(sq_r - sq_trial);
            sroot <= {sroot[23:0], 1'b1};
          end else begin
            srem  <= sq_r[25:0];
            sroot <= {sroot[23:0], 1'b0};
          end
        end
        napsrch_pkg::OP_SAVE_DIST: cand_dist <= sroot;
        napsrch_pkg::OP_UNIT_X:
          ux <= (n == '0) ? 16'sd0 : (wx[CW] ? -$signed(s_rnd) : $signed(s_rnd));
        napsrch_pkg::OP_UNIT_Y:
          uy <= (n == '0) ? 16'sd0 : (wy[CW] ? -$signed(s_rnd) : $signed(s_rnd));
        napsrch_pkg::OP_SET_HEAD: begin
          ox <= ax; oy <= ay; hx <= ux; hy <= uy;
          near_valid <= 1'b0; near_px <= '0; near_py <= '0; near_dist <= '0;
          best_valid <= 1'b0; best_px <= '0; best_py <= '0; best_cos <= COS_MIN;
        end
        napsrch_pkg::OP_UPDATE: begin
          if (!near_valid || near_dist > cand_dist) begin
            near_valid <= 1'b1; near_px <= px; near_py <= py; near_dist <= cand_dist;
          end
          if (!best_valid || best_cos < cos_c) begin
            best_valid <= 1'b1; best_px <= px; best_py <= py; best_cos <= cos_c;
          end
        end
        napsrch_pkg::OP_PUBLISH: begin
          out_valid <= 1'b1;
          out_data  <= {5'd0, best_cos, best_py, best_px, best_valid,
                        near_dist, near_py, near_px, near_valid};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/nearest_and_aligned_point_search.sv =====
// Channel | Dir | Payload
// s_*     | in  | tuser: func[1:0]; tdata: a_x,a_y,b_x,b_y,c_x,c_y,d_x,d_y (24 b each)
// m_*     | out | tdata: found/x/y/dist of nearest, found/x/y/cos of best aligned
//
// One item at a time. Work runs through the shared bit-serial divider (28 steps
// per unit component, plus the 24-step segment divide for a quadrangle whose
// projection does not clamp) and root unit (25 steps, three runs per candidate,
// two per start); an unused selector goes straight to publish. s_tready returns
// in the cycle m_tvalid rises.
// rst is synchronous; results clear and best cosine reads minus one.
// A finished result sits in the output register; the next item is taken
// meanwhile and only its publish waits on m_tready.
module nearest_and_aligned_point_search (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from bit 0
  input  logic [1:0]   s_tuser,  // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata   // nearest_found, nearest_x, nearest_y, nearest_dist,
                                 // aligned_found, aligned_x, aligned_y, aligned_cos,
                                 // zero fill
);

  napsrch_pkg::dp_cmd_t  cmd;
  napsrch_pkg::dp_stat_t stat;
  logic                  in_fire;

  assign in_fire = s_tvalid && s_tready;

  napsrch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  napsrch_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (s_tuser),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 20000;  // cycles with no transfer on either channel
  localparam int DRAIN_WAIT  = 400;    // one slow item plus margin
  localparam logic [23:0] ZERO24 = 24'd0;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] ax, ay, bx, by, cx, cy, dx, dy;
  } cand_item_t;

  typedef struct packed {
    logic        nf;
    logic [23:0] nx, ny;
    logic [24:0] nd;
    logic        af;
    logic [23:0] ax, ay;
    logic [15:0] ac;
  } track_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic [1:0]   s_tuser = napsrch_pkg::FUNC_START;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;

  nearest_and_aligned_point_search dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // search state mirror
  longint org_x, org_y, head_x, head_y;
  bit     nr_ok, al_ok;
  longint nr_x, nr_y, nr_d, al_x, al_y, al_c;

  cand_item_t item_q[$];
  track_t     expect_q[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches, results_seen, stall_cnt;
  int n_start, n_circle, n_quad, n_none;

  // accepted at the last rising edge
  bit s_tready_q;
  cand_item_t took;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint frac_q(longint num, longint den, int bits);
    longint q, r;
    q = 0;
    r = num;
    if (den == 0) return 0;
    if (num >= den) return longint'(1) << bits;
    for (int i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // one Q1.14 component of the unit vector, n = |v|^2
  function automatic longint unit_q14(longint x, longint n);
    longint ax, q, s;
    if (n == 0) return 0;
    ax = x < 0 ? -x : x;
    q = frac_q(ax * ax, n, 28);
    s = int_sqrt(q);
    if (q - s * s > s) s++;
    return x < 0 ? -s : s;
  endfunction

  function automatic void clear_tracks();
    nr_ok = 0; nr_x = 0; nr_y = 0; nr_d = 0;
    al_ok = 0; al_x = 0; al_y = 0; al_c = -16384;
  endfunction

  function automatic void weigh_point(longint px, longint py);
    longint ddx, ddy, n, d, ux, uy, c;
    ddx = px - org_x;
    ddy = py - org_y;
    n = ddx * ddx + ddy * ddy;
    d = int_sqrt(n);
    if (d > 33554431) d = 33554431;
    if (!nr_ok || nr_d > d) begin
      nr_ok = 1; nr_x = px; nr_y = py; nr_d = d;
    end
    ux = unit_q14(ddx, n);
    uy = unit_q14(ddy, n);
    c = asr(ux * head_x + uy * head_y + 8192, 14);
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (!al_ok || al_c < c) begin
      al_ok = 1; al_x = px; al_y = py; al_c = c;
    end
  endfunction

  function automatic track_t search_step(cand_item_t it);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint sx, sy, ex, ey, vx, vy, num, den, px, py, t;
    track_t r;
    ax = longint'($signed(it.ax)); ay = longint'($signed(it.ay));
    bx = longint'($signed(it.bx)); by = longint'($signed(it.by));
    cx = longint'($signed(it.cx)); cy = longint'($signed(it.cy));
    dx = longint'($signed(it.dx)); dy = longint'($signed(it.dy));
    case (it.func)
      napsrch_pkg::FUNC_START: begin
        org_x = ax;
        org_y = ay;
        head_x = unit_q14(bx, bx * bx + by * by);
        head_y = unit_q14(by, bx * bx + by * by);
        clear_tracks();
      end
      napsrch_pkg::FUNC_CIRCLE: weigh_point(ax, ay);
      napsrch_pkg::FUNC_QUAD: begin
        sx = asr(ax + bx, 1); sy = asr(ay + by, 1);
        ex = asr(cx + dx, 1); ey = asr(cy + dy, 1);
        vx = ex - sx; vy = ey - sy;
        num = (org_x - sx) * vx + (org_y - sy) * vy;
        den = vx * vx + vy * vy;
        if (den == 0 || num <= 0) begin
          px = sx; py = sy;
        end else if (num >= den) begin
          px = ex; py = ey;
        end else begin
          t = frac_q(num, den, 24);
          px = sx + asr(vx * t + (longint'(1) << 23), 24);
          py = sy + asr(vy * t + (longint'(1) << 23), 24);
        end
        weigh_point(px, py);
      end
      default: ;
    endcase
    r.nf = nr_ok; r.nx = nr_x[23:0]; r.ny = nr_y[23:0]; r.nd = nr_d[24:0];
    r.af = al_ok; r.ax = al_x[23:0]; r.ay = al_y[23:0]; r.ac = al_c[15:0];
    return r;
  endfunction

  // driver: present items at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_q) begin
        if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser  <= item_q[0].func;
          s_tdata  <= {item_q[0].dy, item_q[0].dx, item_q[0].cy, item_q[0].cx,
                       item_q[0].by, item_q[0].bx, item_q[0].ay, item_q[0].ax};
          void'(item_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    track_t got, exp_r;
    s_tready_q = s_tvalid && s_tready;
    if (rst) begin
      stall_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        took.func = s_tuser;
        {took.dy, took.dx, took.cy, took.cx, took.by, took.bx, took.ay, took.ax} = s_tdata;
        expect_q.push_back(search_step(took));
        case (took.func)
          napsrch_pkg::FUNC_START:  n_start++;
          napsrch_pkg::FUNC_CIRCLE: n_circle++;
          napsrch_pkg::FUNC_QUAD:   n_quad++;
          default:                  n_none++;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[24:1], m_tdata[48:25], m_tdata[73:49], m_tdata[74],
               m_tdata[98:75], m_tdata[122:99], m_tdata[138:123]};
        results_seen++;
        if (expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expect_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch #%0d: nf %0d/%0d n (%h,%h)/(%h,%h) d %0d/%0d",
                       results_seen, exp_r.nf, got.nf, exp_r.nx, exp_r.ny,
                       got.nx, got.ny, exp_r.nd, got.nd);
              $display("  af %0d/%0d a (%h,%h)/(%h,%h) c %0d/%0d",
                       exp_r.af, got.af, exp_r.ax, exp_r.ay, got.ax, got.ay,
                       $signed(exp_r.ac), $signed(got.ac));
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(5))
      0: return 24'($urandom);                  // full range
      1: return 24'(int'($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'(int'($urandom_range(400000)) - 200000);
    endcase
  endfunction

  function automatic cand_item_t mk(logic [1:0] f, logic [23:0] ax, ay, bx, by,
                                    cx, cy, dx, dy);
    cand_item_t it;
    it.func = f; it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
    it.cx = cx; it.cy = cy; it.dx = dx; it.dy = dy;
    return it;
  endfunction

  function automatic cand_item_t rnd_item(logic [1:0] f);
    return mk(f, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
              rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
  endfunction

  task automatic wait_empty();
    while (item_q.size() > 0 || s_tvalid || expect_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    cand_item_t it;
    logic [23:0] sx, sy;
    int len;
    int phase;
    clear_tracks();
    org_x = 0; org_y = 0; head_x = 0; head_y = 0;
    send_idle_pct = 27;
    recv_idle_pct = 84;
    phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: candidate before any start, all selectors, extremes
    item_q.push_back(mk(napsrch_pkg::FUNC_CIRCLE, 24'h000100, 24'h000200,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    item_q.push_back(mk(napsrch_pkg::FUNC_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    item_q.push_back(mk(napsrch_pkg::FUNC_START, ZERO24, ZERO24, 24'h000100,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    // at origin
    item_q.push_back(mk(napsrch_pkg::FUNC_CIRCLE, ZERO24, ZERO24,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    // aligned
    item_q.push_back(mk(napsrch_pkg::FUNC_CIRCLE, 24'h000A00, ZERO24,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    // tie distance
    item_q.push_back(mk(napsrch_pkg::FUNC_CIRCLE, 24'hFFF600, ZERO24,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    item_q.push_back(mk(napsrch_pkg::FUNC_CIRCLE, 24'h7FFFFF, 24'h7FFFFF,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    // zero velocity
    item_q.push_back(mk(napsrch_pkg::FUNC_START, 24'h800000, 24'h800000,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    // largest distance
    item_q.push_back(mk(napsrch_pkg::FUNC_CIRCLE, 24'h7FFFFF, 24'h7FFFFF,
                        ZERO24, ZERO24, ZERO24, ZERO24, ZERO24, ZERO24));
    item_q.push_back(mk(napsrch_pkg::FUNC_QUAD, 24'h800000, 24'h800000, 24'h800000,
                        24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    item_q.push_back(mk(napsrch_pkg::FUNC_START, ZERO24, ZERO24, 24'hFFFF00,
                        24'h000100, ZERO24, ZERO24, ZERO24, ZERO24));
    // zero-length segment, clamps at both ends, interior projection
    item_q.push_back(mk(napsrch_pkg::FUNC_QUAD, 24'h000300, 24'h000500, 24'h000301,
                        24'h000500, 24'h000301, 24'h000500, 24'h000300, 24'h000500));
    item_q.push_back(mk(napsrch_pkg::FUNC_QUAD, 24'h000400, 24'h000100, 24'h000400,
                        24'hFFFF00, 24'h000800, 24'h000100, 24'h000800, 24'hFFFF00));
    item_q.push_back(mk(napsrch_pkg::FUNC_QUAD, 24'hFFF800, 24'h000100, 24'hFFF800,
                        24'hFFFF00, 24'hFFFC00, 24'h000100, 24'hFFFC00, 24'hFFFF00));
    item_q.push_back(mk(napsrch_pkg::FUNC_QUAD, 24'hFFFB00, 24'h000380, 24'hFFFB00,
                        24'h000280, 24'h000533, 24'hFFFD11, 24'h000533, 24'hFFFC07));
    item_q.push_back(mk(napsrch_pkg::FUNC_START, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                        24'h800000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    item_q.push_back(mk(napsrch_pkg::FUNC_QUAD, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                        24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));

    // random: mostly searches of random length, some noise items
    for (int k = 0; k < 900; ) begin
      if (phase == 0 && k >= 300) begin
        wait_empty();
        send_idle_pct = 84;
        recv_idle_pct = 27;
        phase = 1;
      end
      if (phase == 1 && k >= 600) begin
        wait_empty();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
      end
      if ($urandom_range(9) == 0) begin
        item_q.push_back(rnd_item(2'($urandom_range(3))));
        k++;
      end else begin
        item_q.push_back(rnd_item(napsrch_pkg::FUNC_START));
        sx = rnd_coord();
        sy = rnd_coord();
        len = $urandom_range(12, 1);
        for (int j = 0; j < len; j++) begin
          it = rnd_item($urandom_range(1) ? napsrch_pkg::FUNC_CIRCLE
                                          : napsrch_pkg::FUNC_QUAD);
          if ($urandom_range(1)) begin  // cluster candidates near a random point
            it.ax = sx + 24'(int'($urandom_range(4095)) - 2048);
            it.ay = sy + 24'(int'($urandom_range(4095)) - 2048);
          end
          item_q.push_back(it);
        end
        k += len + 1;
      end
      while (item_q.size() > 8) @(posedge clk);
    end
    wait_empty();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d starts, %0d circles, %0d quads, %0d unused selectors",
             n_start, n_circle, n_quad, n_none);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
